// ===== rtl/bcm_pkg.sv =====
//------------------------------------------------------------------------------
// bcm_pkg: shared types and constants for the classifier metrics core
// Widths, metric codes, sequencer states and the log table.
//------------------------------------------------------------------------------
package bcm_pkg;

   localparam int COUNT_BITS = 24;
   localparam int NUM_BINS   = 10;
   localparam int BIN_W      = $clog2(NUM_BINS);
   localparam int BPS_W      = COUNT_BITS + 16;
   localparam int LL_W       = 48;
   localparam int BR_W       = 56;
   localparam int N_W        = COUNT_BITS + 2;
   // ECE sum: up to NUM_BINS * 2^BPS_W
   localparam int ECE_W      = BPS_W + BIN_W + 1;
   // divider operand width: widest dividend
   localparam int DIV_W      = BR_W;
   localparam int DCNT_W     = $clog2(DIV_W + 1);
   localparam logic [16:0] LN2_Q16 = 17'd45426;
   localparam logic [15:0] THR_RESET = 16'd32768;

   typedef enum logic [2:0] {
      MC_N        = 3'd0,
      MC_ACCURACY = 3'd1,
      MC_BALANCED = 3'd2,
      MC_PRECIS   = 3'd3,
      MC_RECALL   = 3'd4,
      MC_LOGLOSS  = 3'd5,
      MC_BRIER    = 3'd6,
      MC_ECE      = 3'd7
   } metric_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_CLEAR,
      ST_ECE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      logic start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [DIV_W-1:0] quo;
   } div_rsp_type;

   // round(65536*ln(1+k/256)) via ln(1+x) = 2 atanh(k/(512+k)), Q62 series
   function automatic logic [15:0] ln_entry(input int unsigned k);
      logic [127:0] z, z2, term, sum;
      z    = (128'(k) << 62) / 128'(512 + k);
      z2   = (z * z) >> 62;
      term = z;
      sum  = '0;
      for (int j = 0; j < 64; j++) begin
         if (term != '0) begin
            sum  = sum + term / 128'(2 * j + 1);
            term = (term * z2) >> 62;
         end
      end
      sum = sum << 1;
      return 16'((sum + (128'd1 << 45)) >> 46);
   endfunction

   function automatic logic [256*16-1:0] ln_rom_build();
      logic [256*16-1:0] t;
      for (int k = 0; k < 256; k++) t[k*16 +: 16] = ln_entry(k);
      return t;
   endfunction

   localparam logic [256*16-1:0] LN_ROM = ln_rom_build();

   function automatic logic [15:0] ln_tab(input logic [7:0] k);
      return LN_ROM[{k, 4'd0} +: 16];
   endfunction

endpackage

// ===== rtl/bcm_divider.sv =====
//------------------------------------------------------------------------------
// bcm_divider: restoring divider, one quotient bit per cycle
// Unsigned num / den over DIV_W bits; den of zero is never started.
//------------------------------------------------------------------------------
module bcm_divider
   import bcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DIV_W:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]  den_ff, den_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_W:0]    shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
      if (req.start) begin
         quo_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
         cnt_in  = DCNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = shifted - {1'b0, den_ff};
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req.start) else $error("start while busy");
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == '0) else $error("count left over");

endmodule

// ===== rtl/binary_classifier_metrics_core.sv =====
//------------------------------------------------------------------------------
// binary_classifier_metrics_core: confusion matrix, log loss, Brier and ECE
// Accumulates per-prediction statistics; on the last item emits 8 metrics.
//------------------------------------------------------------------------------
// channel  ports                                  direction
// req      req_valid/ready, probability,label,last  in
// rsp      rsp_valid/ready, code,value,undef,last   out
// csr      csr_write_enable, csr_write_data         in
//
// Non-last item: accept, square, accumulate.
// Last item: adds the ECE walk over the NUM_BINS bins, then the divides on
// the shared bit-serial divider (two divides for balanced accuracy), plus
// one result transfer per metric; the sums are cleared bin by bin after
// the eighth result.
// req_ready is low while an item is in work; rsp stalls hold the sequencer.
//------------------------------------------------------------------------------
module binary_classifier_metrics_core
   import bcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_probability,
   input  logic        req_label,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_metric_code,
   output logic [23:0] rsp_metric_value,
   output logic        rsp_undefined,
   output logic        rsp_last_result,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   state_type state_ff, state_in;
   logic [15:0] thr_ff;
   logic [15:0] prob_ff;
   logic        lab_ff, last_ff;
   logic [COUNT_BITS-1:0] tp_ff, tn_ff, fp_ff, fn_ff;
   logic [LL_W-1:0]  ll_ff;
   logic [BR_W-1:0]  br_ff;
   logic [BPS_W-1:0] bps_ff [NUM_BINS];
   logic [COUNT_BITS-1:0] bls_ff [NUM_BINS];
   logic [ECE_W-1:0] ece_ff;
   logic [BIN_W-1:0] bin_ff;
   logic [2:0]  code_ff, code_in;
   logic        half_ff;   // balanced accuracy: second ratio pending
   logic [DIV_W-1:0] tpr_ff;
   logic [31:0] sq_ff;
   logic [23:0] val_ff;
   logic        und_ff;
   logic        div_start;
   div_req_type dreq;
   div_rsp_type drsp;

   // per-item combinational terms
   logic [16:0] diff;
   logic [16:0] q;
   logic [3:0]  lead;
   logic [7:0]  frac;
   logic [20:0] nl;
   logic [19:0] binp;
   logic [BIN_W-1:0] bin;
   logic        pos;
   logic [N_W-1:0] n;
   logic [BPS_W-1:0] lsh, ad;
   logic [DIV_W-1:0] num, den;
   logic        dz;
   logic [DIV_W-1:0] val;

   always_comb begin
      diff = lab_ff ? 17'h10000 - {1'b0, prob_ff} : {1'b0, prob_ff};
      q    = lab_ff ? {1'b0, prob_ff} : 17'h10000 - {1'b0, prob_ff};
      lead = '0;
      for (int i = 0; i < 16; i++) if (q[i]) lead = 4'(i);
      frac = 8'((q[15:0] << (4'd15 - lead)) >> 7);
      nl   = 21'(5'd16 - {1'b0, lead}) * 21'(LN2_Q16) - 21'(ln_tab(frac));
      binp = 20'((36'(prob_ff) * NUM_BINS) >> 16);
      bin  = (binp >= 20'(NUM_BINS)) ? BIN_W'(NUM_BINS - 1) : BIN_W'(binp);
      pos  = prob_ff >= thr_ff;
      n    = N_W'(tp_ff) + N_W'(tn_ff) + N_W'(fp_ff) + N_W'(fn_ff);
      lsh  = {bls_ff[bin_ff], 16'd0};
      ad   = (bps_ff[bin_ff] >= lsh) ? bps_ff[bin_ff] - lsh : lsh - bps_ff[bin_ff];
   end

   // dividend / divisor for the current code
   always_comb begin
      num = '0;
      den = DIV_W'(n);
      unique case (metric_type'(code_ff))
         MC_ACCURACY: num = DIV_W'(N_W'(tp_ff) + N_W'(tn_ff)) << 16;
         MC_BALANCED: begin
            if (!half_ff) begin
               num = DIV_W'(tp_ff) << 16;
               den = DIV_W'(N_W'(tp_ff) + N_W'(fn_ff));
            end else begin
               num = DIV_W'(tn_ff) << 16;
               den = DIV_W'(N_W'(tn_ff) + N_W'(fp_ff));
            end
         end
         MC_PRECIS: begin
            num = DIV_W'(tp_ff) << 16;
            den = DIV_W'(N_W'(tp_ff) + N_W'(fp_ff));
         end
         MC_RECALL: begin
            num = DIV_W'(tp_ff) << 16;
            den = DIV_W'(N_W'(tp_ff) + N_W'(fn_ff));
         end
         MC_LOGLOSS: num = DIV_W'(ll_ff);
         MC_BRIER:   num = br_ff;
         MC_ECE:     num = DIV_W'(ece_ff);
         MC_N:       num = '0;
         default:    num = '0;
      endcase
      dz = (den == '0);
      if (code_ff == MC_BALANCED) begin
         dz = (N_W'(tp_ff) + N_W'(fn_ff) == '0) || (N_W'(tn_ff) + N_W'(fp_ff) == '0);
      end
   end

   assign dreq = {div_start, num, den};

   always_comb begin
      val = drsp.quo;
      if (code_ff == MC_BRIER) val = drsp.quo >> 16;
      if (code_ff == MC_BALANCED) val = DIV_W'((65'(tpr_ff) + 65'(drsp.quo)) >> 1);
   end

   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_CLEAR;
         ST_CLEAR: state_in = ST_ACCUM;
         ST_ACCUM: state_in = last_ff ? ST_ECE : ST_IDLE;
         ST_ECE: begin
            if (bin_ff == BIN_W'(NUM_BINS - 1)) begin
               state_in = ST_EMIT;
               code_in  = MC_N;
            end
         end
         ST_DIV_START: begin
            if (dz) state_in = ST_EMIT;
            else begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (drsp.done) begin
               if (code_ff == MC_BALANCED && !half_ff) state_in = ST_DIV_START;
               else state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               code_in = code_ff + 3'd1;
               state_in = (code_ff == MC_ECE) ? ST_SWEEP : ST_DIV_START;
            end
         end
         ST_SWEEP: if (bin_ff == BIN_W'(NUM_BINS - 1)) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   logic emit_load;
   assign emit_load = (state_ff == ST_ECE && bin_ff == BIN_W'(NUM_BINS - 1))
      || (state_ff == ST_DIV_START && dz)
      || (state_ff == ST_DIV_WAIT && drsp.done
          && !(code_ff == MC_BALANCED && !half_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         thr_ff   <= THR_RESET;
         code_ff  <= MC_N;
         bin_ff   <= '0;
         half_ff  <= 1'b0;
         tp_ff <= '0; tn_ff <= '0; fp_ff <= '0; fn_ff <= '0;
         ll_ff <= '0; br_ff <= '0;
         for (int i = 0; i < NUM_BINS; i++) begin
            bps_ff[i] <= '0;
            bls_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
         if (csr_write_enable) thr_ff <= csr_write_data;
         if (state_ff == ST_IDLE && req_valid) begin
            prob_ff <= (req_probability == 16'd0) ? 16'd1 : req_probability;
            lab_ff  <= req_label;
            last_ff <= req_last_item;
         end
         if (state_ff == ST_CLEAR) sq_ff <= 32'(diff) * 32'(diff);
         if (state_ff == ST_ACCUM) begin
            if (pos && lab_ff)   tp_ff <= tp_ff + 1'b1;
            if (!pos && !lab_ff) tn_ff <= tn_ff + 1'b1;
            if (pos && !lab_ff)  fp_ff <= fp_ff + 1'b1;
            if (!pos && lab_ff)  fn_ff <= fn_ff + 1'b1;
            ll_ff <= ll_ff + LL_W'(nl);
            br_ff <= br_ff + BR_W'({diff[16], sq_ff} & 33'h1_FFFF_FFFF) +
                     (diff[16] ? BR_W'(34'h1_0000_0000) : '0);
            bps_ff[bin] <= bps_ff[bin] + BPS_W'(prob_ff);
            bls_ff[bin] <= bls_ff[bin] + COUNT_BITS'(lab_ff);
            bin_ff <= '0;
            ece_ff <= '0;
         end
         if (state_ff == ST_ECE) begin
            ece_ff <= ece_ff + ECE_W'(ad);
            bin_ff <= (bin_ff == BIN_W'(NUM_BINS - 1)) ? '0 : bin_ff + 1'b1;
         end
         if (state_ff == ST_DIV_WAIT && drsp.done && code_ff == MC_BALANCED) begin
            half_ff <= ~half_ff;
            tpr_ff  <= drsp.quo;
         end
         if (state_ff == ST_SWEEP) begin
            bps_ff[bin_ff] <= '0;
            bls_ff[bin_ff] <= '0;
            bin_ff <= (bin_ff == BIN_W'(NUM_BINS - 1)) ? '0 : bin_ff + 1'b1;
            if (bin_ff == BIN_W'(NUM_BINS - 1)) begin
               tp_ff <= '0; tn_ff <= '0; fp_ff <= '0; fn_ff <= '0;
               ll_ff <= '0; br_ff <= '0;
            end
         end
      end
      if (emit_load) begin
         if (state_ff == ST_ECE) begin
            val_ff <= (n > N_W'(24'hFFFFFF)) ? 24'hFFFFFF : 24'(n);
            und_ff <= 1'b0;
         end else if (state_ff == ST_DIV_START) begin
            val_ff <= '0;
            und_ff <= 1'b1;
         end else begin
            val_ff <= (val > DIV_W'(24'hFFFFFF)) ? 24'hFFFFFF : 24'(val);
            und_ff <= 1'b0;
         end
      end
   end

   bcm_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = (state_ff == ST_EMIT);
   assign rsp_metric_code  = code_ff;
   assign rsp_metric_value = val_ff;
   assign rsp_undefined    = und_ff;
   assign rsp_last_result  = (code_ff == MC_ECE);

   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready during emit");
   a_und_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_undefined |-> rsp_metric_value == '0)
      else $error("undefined with value");
   a_n_def: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_metric_code == MC_N |-> !rsp_undefined)
      else $error("count undefined");
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_metric_code != MC_ECE |=>
      rsp_metric_code == $past(rsp_metric_code) + 3'd1)
      else $error("code order");

endmodule

// ===== tb/sv/binary_classifier_metrics_core_test.sv =====
//------------------------------------------------------------------------------
// binary_classifier_metrics_core_test: self-checking bench for the metrics core
// Streams prediction sets with random flow control and compares every metric
// transfer against an in-bench scoring model, across several thresholds.
//------------------------------------------------------------------------------
module binary_classifier_metrics_core_test;
   import bcm_pkg::*;

   typedef struct {
      logic [15:0] prob;
      logic        label;
      logic        fin;
   } prediction_type;

   typedef struct {
      metric_type  code;
      logic [23:0] value;
      logic        undef;
      logic        fin;
   } metric_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_probability = '0;
   logic        req_label = 1'b0;
   logic        req_last_item = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_metric_code;
   logic [23:0] rsp_metric_value;
   logic        rsp_undefined;
   logic        rsp_last_result;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;

   prediction_type  pending[$];
   metric_item_type metrics_due[$];
   int          errors = 0;
   bit          calm = 1'b0;       // no idling on either side
   bit          long_hold_go = 1'b0;
   bit          long_hold_done = 1'b0;
   int          hold_left = 0;
   int          item_total = 0;

   // scoring model state
   logic [15:0] thr_model;
   logic [23:0] tp_cnt, tn_cnt, fp_cnt, fn_cnt;
   logic [47:0] ll_sum;
   logic [55:0] br_sum;
   logic [39:0] bin_ps [NUM_BINS];
   logic [23:0] bin_ls [NUM_BINS];
   int unsigned ln_q16 [256];

   binary_classifier_metrics_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_probability(req_probability), .req_label(req_label),
      .req_last_item(req_last_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_metric_code(rsp_metric_code), .rsp_metric_value(rsp_metric_value),
      .rsp_undefined(rsp_undefined), .rsp_last_result(rsp_last_result),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned quotient(longint unsigned num,
                                                longint unsigned den);
      return den == 0 ? 0 : (num << 16) / den;
   endfunction

   task automatic push_metric(metric_type code, longint unsigned value, bit undef);
      metric_item_type m;
      m.code  = code;
      m.value = undef ? 24'd0 : (value > 64'hFFFFFF ? 24'hFFFFFF : value[23:0]);
      m.undef = undef;
      m.fin   = (code == MC_ECE);
      metrics_due.push_back(m);
   endtask

   task automatic clear_sums();
      tp_cnt = 0; tn_cnt = 0; fp_cnt = 0; fn_cnt = 0;
      ll_sum = 0; br_sum = 0;
      for (int b = 0; b < NUM_BINS; b++) begin
         bin_ps[b] = 0;
         bin_ls[b] = 0;
      end
   endtask

   task automatic score_prediction(prediction_type it);
      longint unsigned p, q, k, bin, n, ece, ls, tp, tn, fp, fn;
      longint          diff;
      int              e;
      bit              pos;
      p = (it.prob == 0) ? 1 : it.prob;
      pos = p >= thr_model;
      if (pos && it.label) tp_cnt++;
      if (!pos && !it.label) tn_cnt++;
      if (pos && !it.label) fp_cnt++;
      if (!pos && it.label) fn_cnt++;
      q = it.label ? p : 65536 - p;
      e = 15;
      while (e > 0 && q[e] == 1'b0) e--;
      k = ((q << (15 - e)) >> 7) & 255;
      ll_sum += (16 - e) * 45426 - ln_q16[k];
      diff = longint'(p) - (it.label ? 65536 : 0);
      br_sum += diff * diff;
      bin = (p * NUM_BINS) >> 16;
      if (bin >= NUM_BINS) bin = NUM_BINS - 1;
      bin_ps[bin] += p;
      bin_ls[bin] += it.label;
      if (!it.fin) return;
      tp = tp_cnt; tn = tn_cnt; fp = fp_cnt; fn = fn_cnt;
      n = tp + tn + fp + fn;
      ece = 0;
      for (int b = 0; b < NUM_BINS; b++) begin
         ls = longint'(bin_ls[b]) << 16;
         ece += (bin_ps[b] >= ls) ? bin_ps[b] - ls : ls - bin_ps[b];
      end
      push_metric(MC_N, n, 1'b0);
      push_metric(MC_ACCURACY, quotient(tp + tn, n), n == 0);
      push_metric(MC_BALANCED, (quotient(tp, tp + fn) + quotient(tn, tn + fp)) >> 1,
                  (tp + fn) == 0 || (tn + fp) == 0);
      push_metric(MC_PRECIS, quotient(tp, tp + fp), (tp + fp) == 0);
      push_metric(MC_RECALL, quotient(tp, tp + fn), (tp + fn) == 0);
      push_metric(MC_LOGLOSS, n == 0 ? 0 : ll_sum / n, n == 0);
      push_metric(MC_BRIER, n == 0 ? 0 : (br_sum / n) >> 16, n == 0);
      push_metric(MC_ECE, n == 0 ? 0 : ece / n, n == 0);
      clear_sums();
   endtask

   // request driver
   always @(posedge clock) begin
      prediction_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) score_prediction('{req_probability, req_label, req_last_item});
         if (pending.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
            it = pending.pop_front();
            req_valid       <= 1'b1;
            req_probability <= it.prob;
            req_label       <= it.label;
            req_last_item   <= it.fin;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      metric_item_type m;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (metrics_due.size() == 0) begin
               $display("%0t: unexpected metric transfer code %0d value %0d", $time,
                        rsp_metric_code, rsp_metric_value);
               errors++;
            end else begin
               m = metrics_due.pop_front();
               if (rsp_metric_code !== m.code || rsp_metric_value !== m.value ||
                   rsp_undefined !== m.undef || rsp_last_result !== m.fin) begin
                  $display("%0t: metric mismatch expected code %0d value %0d undef %0b last %0b",
                           $time, m.code, m.value, m.undef, m.fin);
                  $display("%0t:                 actual   code %0d value %0d undef %0b last %0b",
                           $time, rsp_metric_code, rsp_metric_value, rsp_undefined,
                           rsp_last_result);
                  errors++;
               end
            end
         end
         if (long_hold_go && !long_hold_done) begin
            long_hold_done <= 1'b1;
            hold_left <= 400;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || $urandom_range(99) >= 29;
         end
      end
   end

   task automatic add_item(logic [15:0] p, logic y, logic fin);
      pending.push_back('{p, y, fin});
      item_total++;
   endtask

   task automatic drain();
      while (pending.size() > 0 || req_valid || metrics_due.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_threshold(logic [15:0] thr);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= thr;
      thr_model = thr;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_sets(int count);
      int len;
      logic [15:0] p;
      int pick;
      for (int s = 0; s < count; s++) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(19);
            if (pick == 0) p = 16'd0;
            else if (pick == 1) p = 16'hFFFF;
            else if (pick == 2) p = thr_model;
            else p = 16'($urandom);
            add_item(p, 1'($urandom_range(1)), i == len - 1);
         end
      end
   endtask

   initial begin
      logic [15:0] thr_list [6];
      for (int k = 0; k < 256; k++)
         ln_q16[k] = $rtoi(65536.0 * $ln(1.0 + k / 256.0) + 0.5);
      thr_model = THR_RESET;
      clear_sums();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, threshold edges, one-class sets
      add_item(16'd0, 1'b0, 1'b0);
      add_item(16'd0, 1'b1, 1'b0);
      add_item(16'hFFFF, 1'b1, 1'b0);
      add_item(16'hFFFF, 1'b0, 1'b0);
      add_item(16'd32768, 1'b1, 1'b0);
      add_item(16'd32767, 1'b0, 1'b0);
      add_item(16'd1, 1'b1, 1'b0);
      add_item(16'd6554, 1'b0, 1'b1);
      add_item(16'd40000, 1'b1, 1'b1);        // single item set
      add_item(16'd100, 1'b0, 1'b0);          // negatives only
      add_item(16'd65000, 1'b0, 1'b1);
      add_item(16'd20000, 1'b1, 1'b0);        // positives, none predicted
      add_item(16'd10, 1'b1, 1'b1);
      drain();

      // threshold extremes; zero makes every prediction positive
      thr_list = '{16'd0, 16'd1, 16'hFFFF, 16'd32768, 16'h5555, 16'hAAAA};
      foreach (thr_list[t]) begin
         set_threshold(thr_list[t]);
         add_item(16'd0, 1'b0, 1'b0);
         add_item(16'hFFFE, 1'b1, 1'b0);
         add_item(16'hFFFF, 1'b1, 1'b1);
         random_sets(6);
         if (t == 2) begin
            calm = 1'b1;
            random_sets(4);
         end
         drain();
         calm = 1'b0;
      end

      // results held back while the sender keeps offering
      long_hold_go = 1'b1;
      random_sets(8);
      drain();

      while (item_total < 500) begin
         set_threshold(16'($urandom));
         random_sets(5);
         drain();
      end

      if (errors == 0)
         $display("binary_classifier_metrics_core_test: clean");
      else
         $display("binary_classifier_metrics_core_test: errors");
      $finish;
   end

   initial begin
      #20000000;
      $display("binary_classifier_metrics_core_test: errors");
      $finish;
   end

endmodule

// ===== binary_classifier_metrics_core.f =====
rtl/bcm_pkg.sv
rtl/bcm_divider.sv
rtl/binary_classifier_metrics_core.sv
tb/sv/binary_classifier_metrics_core_test.sv
